FILE: rtl/insertion_sort_engine_macros.svh
// assertion macros used by the one asserting file, insertion_sort_engine.sv
`ifndef INSERTION_SORT_ENGINE_MACROS_SVH
`define INSERTION_SORT_ENGINE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ISE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ISE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ise_pkg.sv
`default_nettype none

package ise_pkg;

  localparam int DATA_W       = 32;
  localparam int REQ_W        = 2;
  localparam int RANK_W       = 6;
  localparam int HELD_W       = 7;
  localparam int STAT_W       = 2;
  localparam int DEF_CAPACITY = 64;

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                     ins;
    logic                     rd_load;
    logic                     rd_shift;
    logic signed [DATA_W-1:0] value;
  } ctl_t;

endpackage

`default_nettype wire

FILE: rtl/ise_cell.sv
`default_nettype none

module ise_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  wire                               clk_i,
  input  wire ise_pkg::ctl_t                ctl_i,
  input  wire [CNT_W-1:0]                   count_i,
  input  wire logic signed [ise_pkg::DATA_W-1:0] prev_val_i,
  input  wire                               prev_gt_i,
  input  wire                               prev_occ_i,
  input  wire [ise_pkg::DATA_W-1:0]         rd_next_i,
  output logic signed [ise_pkg::DATA_W-1:0] val_o,
  output logic                              gt_o,
  output logic                              occ_o,
  output logic [ise_pkg::DATA_W-1:0]        rd_o
);

  logic signed [ise_pkg::DATA_W-1:0] val_q, val_d;
  logic [ise_pkg::DATA_W-1:0]        rd_q, rd_d;

  assign occ_o = count_i > CNT_W'(IDX);
  assign gt_o  = occ_o && (val_q > ctl_i.value);
  assign val_o = val_q;
  assign rd_o  = rd_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.ins) begin
      if (prev_gt_i) begin
        val_d = prev_val_i;
      end else if (gt_o || (prev_occ_i && !occ_o)) begin
        // first larger entry, or the free slot just past the end
        val_d = ctl_i.value;
      end
    end
  end

  always_comb begin
    rd_d = rd_q;
    if (ctl_i.rd_load) begin
      rd_d = val_q;
    end else if (ctl_i.rd_shift) begin
      rd_d = rd_next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rd_q  <= rd_d;
  end

endmodule

`default_nettype wire

FILE: rtl/insertion_sort_engine.sv
// insertion sort engine: a row of compare-and-shift cells holding the sorted set
// clear and insert: result registered next cycle; one request per cycle unless stalled
// read: snapshot of the row shifts toward cell 0, result registered once the entry is there
// the row shifts one cell per cycle, so a read blocks new requests until its result is taken
// reset: count zero, output empty; cell contents stay undefined, no clearing pass
`default_nettype none

`include "insertion_sort_engine_macros.svh"

module insertion_sort_engine #(
  parameter int CAPACITY = ise_pkg::DEF_CAPACITY
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_stall_o,
  input  wire [ise_pkg::REQ_W-1:0]               req_type_i,
  input  wire logic signed [ise_pkg::DATA_W-1:0] value_i,
  input  wire [ise_pkg::RANK_W-1:0]              rank_i,
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output logic signed [ise_pkg::DATA_W-1:0]      result_value_o,
  output logic [ise_pkg::HELD_W-1:0]             held_count_o,
  output logic [ise_pkg::STAT_W-1:0]             status_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > ise_pkg::RANK_W) ? CNT_W : ise_pkg::RANK_W;

  typedef enum logic {S_IDLE, S_READ} state_e;

  state_e                            state_q;
  logic [CNT_W-1:0]                  count_q;
  logic [ise_pkg::RANK_W-1:0]        cnt_q;
  logic                              out_valid_q;
  logic signed [ise_pkg::DATA_W-1:0] res_val_q;
  logic [ise_pkg::HELD_W-1:0]        held_q;
  logic [ise_pkg::STAT_W-1:0]        status_q;

  logic          out_free, accept, full, in_range;
  logic          rd_done, res_load, ins_refused;
  ise_pkg::ctl_t ctl;

  logic signed [ise_pkg::DATA_W-1:0] cell_val [CAPACITY];
  logic                              cell_gt  [CAPACITY];
  logic                              cell_occ [CAPACITY];
  logic [ise_pkg::DATA_W-1:0]        cell_rd  [CAPACITY];

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = count_q == CNT_W'(CAPACITY);
  assign in_range   = CMP_W'(rank_i) < CMP_W'(count_q);

  assign ctl.ins      = accept && (req_type_i == ise_pkg::REQ_INSERT) && !full;
  assign ctl.rd_load  = accept && (req_type_i == ise_pkg::REQ_READ) && in_range;
  assign ctl.rd_shift = (state_q == S_READ) && (cnt_q != '0);
  assign ctl.value    = value_i;

  // requested entry has reached cell 0 and the output can take it
  assign rd_done     = (state_q == S_READ) && (cnt_q == '0) && out_free;
  assign res_load    = (accept && !ctl.rd_load) || rd_done;
  assign ins_refused = accept && (req_type_i == ise_pkg::REQ_INSERT) && full;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ise_pkg::DATA_W-1:0] prev_val;
    logic                              prev_gt, prev_occ;
    logic [ise_pkg::DATA_W-1:0]        rd_next;

    if (i == 0) begin : g_head
      assign prev_val = '0;
      assign prev_gt  = 1'b0;
      assign prev_occ = 1'b1;
    end else begin : g_body
      assign prev_val = cell_val[i-1];
      assign prev_gt  = cell_gt[i-1];
      assign prev_occ = cell_occ[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rd_next = '0;
    end else begin : g_link
      assign rd_next = cell_rd[i+1];
    end

    ise_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .count_i    (count_q),
      .prev_val_i (prev_val),
      .prev_gt_i  (prev_gt),
      .prev_occ_i (prev_occ),
      .rd_next_i  (rd_next),
      .val_o      (cell_val[i]),
      .gt_o       (cell_gt[i]),
      .occ_o      (cell_occ[i]),
      .rd_o       (cell_rd[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      res_val_q   <= '0;
      held_q      <= '0;
      status_q    <= ise_pkg::ST_OK;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (req_type_i)
              ise_pkg::REQ_CLEAR: begin
                count_q   <= '0;
                res_val_q <= '0;
                held_q    <= '0;
                status_q  <= ise_pkg::ST_OK;
              end
              ise_pkg::REQ_INSERT: begin
                res_val_q <= '0;
                if (full) begin
                  held_q   <= ise_pkg::HELD_W'(count_q);
                  status_q <= ise_pkg::ST_FULL;
                end else begin
                  count_q  <= count_q + CNT_W'(1);
                  held_q   <= ise_pkg::HELD_W'(count_q + CNT_W'(1));
                  status_q <= ise_pkg::ST_OK;
                end
              end
              ise_pkg::REQ_READ: begin
                if (in_range) begin
                  state_q <= S_READ;
                  cnt_q   <= rank_i;
                end else begin
                  res_val_q <= '0;
                  held_q    <= ise_pkg::HELD_W'(count_q);
                  status_q  <= ise_pkg::ST_RANGE;
                end
              end
              default: begin
                res_val_q <= '0;
                held_q    <= ise_pkg::HELD_W'(count_q);
                status_q  <= ise_pkg::ST_OK;
              end
            endcase
          end
        end
        S_READ: begin
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - ise_pkg::RANK_W'(1);
          end else if (out_free) begin
            res_val_q <= cell_rd[0];
            held_q    <= ise_pkg::HELD_W'(count_q);
            status_q  <= ise_pkg::ST_OK;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_val_q;
  assign held_count_o   = held_q;
  assign status_o       = status_q;

  `ISE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `ISE_ASSERT_NEXT(a_full_hold, ins_refused, $stable(count_q), "full insert changed count")
  `ISE_ASSERT_NOW(a_read_blocks, state_q == S_READ, in_stall_o, "request taken during read")
  `ISE_ASSERT_NEXT(a_read_enter, ctl.rd_load, state_q == S_READ && cnt_q == $past(rank_i), "read start")

endmodule

`default_nettype wire

FILE: test/tb_insertion_sort_engine.sv
`timescale 1ns / 100ps

module tb_insertion_sort_engine;
  import ise_pkg::*;

  localparam int SORT_CAPACITY = DEF_CAPACITY;
  localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_CYCLES = 100;

  typedef enum int {VAL_WIDE, VAL_NARROW, VAL_EXTREME} value_mode_e;

  typedef struct {
    logic [REQ_W-1:0]         kind;
    logic signed [DATA_W-1:0] value;
    logic [RANK_W-1:0]        rank;
  } sort_request_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [HELD_W-1:0]        held;
    logic [STAT_W-1:0]        status;
  } sort_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [REQ_W-1:0]         req_type_i;
  logic signed [DATA_W-1:0] value_i;
  logic [RANK_W-1:0]        rank_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] result_value_o;
  logic [HELD_W-1:0]        held_count_o;
  logic [STAT_W-1:0]        status_o;

  sort_request_t pending_requests[$];
  sort_result_t  expected_results[$];

  // sorted set as the block should hold it
  logic signed [DATA_W-1:0] shadow_store [SORT_CAPACITY];
  int shadow_count = 0;

  // count as seen while building stimulus, used to aim reads at filled ranks
  int gen_count = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int requests_pushed = 0;
  int requests_taken = 0;
  int mismatch_count = 0;
  bit req_taken = 1'b0;

  insertion_sort_engine #(
    .CAPACITY(SORT_CAPACITY)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .value_i        (value_i),
    .rank_i         (rank_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .held_count_o   (held_count_o),
    .status_o       (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic sort_result_t apply_sort_request(sort_request_t rq);
    sort_result_t rs;
    int pos;
    rs.value = '0;
    rs.status = ST_OK;
    case (rq.kind)
      REQ_CLEAR: begin
        shadow_count = 0;
      end
      REQ_INSERT: begin
        if (shadow_count >= SORT_CAPACITY) begin
          rs.status = ST_FULL;
        end else begin
          // shift strictly greater values up, so equal values keep arrival order
          pos = shadow_count;
          while (pos > 0 && shadow_store[pos-1] > rq.value) begin
            shadow_store[pos] = shadow_store[pos-1];
            pos--;
          end
          shadow_store[pos] = rq.value;
          shadow_count++;
        end
      end
      REQ_READ: begin
        if (rq.rank < shadow_count) begin
          rs.value = shadow_store[rq.rank];
        end else begin
          rs.status = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
    rs.held = HELD_W'(shadow_count);
    return rs;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value(value_mode_e mode);
    logic signed [DATA_W-1:0] v;
    case (mode)
      VAL_WIDE: v = $urandom();
      VAL_NARROW: v = $signed($urandom_range(16)) - 8;
      default: begin
        case ($urandom_range(4))
          0: v = 32'sh7fffffff;
          1: v = 32'sh80000000;
          2: v = '0;
          3: v = -1;
          default: v = $urandom();
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic push_req(logic [REQ_W-1:0] kind, logic signed [DATA_W-1:0] value,
                          logic [RANK_W-1:0] rank);
    sort_request_t rq;
    rq.kind = kind;
    rq.value = value;
    rq.rank = rank;
    pending_requests.push_back(rq);
    requests_pushed++;
    if (kind == REQ_CLEAR) begin
      gen_count = 0;
    end else if (kind == REQ_INSERT && gen_count < SORT_CAPACITY) begin
      gen_count++;
    end
  endtask

  task automatic push_read(int in_range_pct);
    if (gen_count > 0 && $urandom_range(99) < in_range_pct) begin
      push_req(REQ_READ, $urandom(), $urandom_range(gen_count - 1));
    end else begin
      push_req(REQ_READ, $urandom(), $urandom_range(SORT_CAPACITY - 1));
    end
  endtask

  task automatic push_directed();
    push_req(REQ_READ, '0, '0);
    push_req(REQ_RESERVED, -1, '1);
    push_req(REQ_INSERT, '0, '0);
    push_req(REQ_INSERT, 32'sh7fffffff, '0);
    push_req(REQ_INSERT, 32'sh80000000, '0);
    push_req(REQ_INSERT, -1, '0);
    push_req(REQ_INSERT, 32'sh7fffffff, '0);
    push_req(REQ_INSERT, 32'sh80000000, '0);
    push_req(REQ_INSERT, '0, '1);
    push_req(REQ_INSERT, 1, '0);
    push_req(REQ_READ, '0, 6'd0);
    push_req(REQ_READ, '0, 6'd1);
    push_req(REQ_READ, -1, 6'd7);
    push_req(REQ_READ, '0, 6'd4);
    push_req(REQ_READ, '0, 6'd8);
    push_req(REQ_READ, '0, '1);
    push_req(REQ_RESERVED, '0, '0);
    // unused fields set to all ones must not matter
    push_req(REQ_CLEAR, -1, '1);
    push_req(REQ_READ, '0, 6'd0);
    push_req(REQ_INSERT, 5, '1);
    push_req(REQ_READ, 32'sh7fffffff, 6'd0);
    push_req(REQ_CLEAR, '0, '0);
  endtask

  // mostly a clear, a fill with reads mixed in, then a burst of reads
  task automatic push_sequence();
    value_mode_e mode;
    int n_ins;
    int n_rd;
    mode = value_mode_e'($urandom_range(2));
    if ($urandom_range(99) < 85) begin
      push_req(REQ_CLEAR, $urandom(), $urandom());
    end
    // some sequences run past capacity to hit the full store
    n_ins = ($urandom_range(3) == 0) ? $urandom_range(72, 60) : $urandom_range(40, 1);
    for (int i = 0; i < n_ins; i++) begin
      push_req(REQ_INSERT, pick_value(mode), $urandom());
      if ($urandom_range(99) < 30) begin
        push_read(90);
      end
      if ($urandom_range(99) < 3) begin
        push_req(REQ_RESERVED, $urandom(), $urandom());
      end
    end
    n_rd = $urandom_range(20, 4);
    for (int i = 0; i < n_rd; i++) begin
      push_read(85);
    end
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int n_items, bit with_directed);
    int target;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = requests_pushed + n_items;
    if (with_directed) begin
      push_directed();
    end
    while (requests_pushed < target) begin
      push_sequence();
    end
    while (pending_requests.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // request side: a new request only once the current one was taken
  always @(negedge clk_i) begin
    sort_request_t nxt;
    if (rst_ni && (!in_valid_i || req_taken)) begin
      req_taken = 1'b0;
      if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_requests.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= nxt.kind;
        value_i    <= nxt.value;
        rank_i     <= nxt.rank;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    sort_request_t rq;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      rq.kind = req_type_i;
      rq.value = value_i;
      rq.rank = rank_i;
      expected_results.push_back(apply_sort_request(rq));
      requests_taken++;
      req_taken = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    sort_result_t exp_rs;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected result: value %0d held %0d status %0d",
                   result_value_o, held_count_o, status_o);
        end
      end else begin
        exp_rs = expected_results.pop_front();
        if (result_value_o !== exp_rs.value || held_count_o !== exp_rs.held ||
            status_o !== exp_rs.status) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: expected value %0d held %0d status %0d, got %0d %0d %0d",
                     exp_rs.value, exp_rs.held, exp_rs.status,
                     result_value_o, held_count_o, status_o);
          end
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = REQ_CLEAR;
    value_i = '0;
    rank_i = '0;
    out_stall_i = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_phase(16, 54, 350, 1'b1);
    run_phase(54, 16, 350, 1'b0);
    run_phase(0, 0, 350, 1'b0);

    while (requests_taken != requests_pushed || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    // catch stray results after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: insertion_sort_engine.f
+incdir+rtl
rtl/ise_pkg.sv
rtl/ise_cell.sv
rtl/insertion_sort_engine.sv
test/tb_insertion_sort_engine.sv
